// ===== rtl/rbnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared types and constants of the ray versus box nearest-hit block.
// ----------------------------------------------------------------------------
package rbnh_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ID_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam int COORD_BITS = 32;
   localparam int NUM_BITS   = 34;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAY_DX   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAY_DY   = 2'd3;

   localparam logic [2:0] NORM_NONE  = 3'd0;
   localparam logic [2:0] NORM_NEG_X = 3'd1;
   localparam logic [2:0] NORM_POS_X = 3'd2;
   localparam logic [2:0] NORM_NEG_Y = 3'd3;
   localparam logic [2:0] NORM_POS_Y = 3'd4;

   // one classified box waiting for the slab divisions
   typedef struct packed {
      logic signed [NUM_BITS-1:0] num_l;
      logic signed [NUM_BITS-1:0] num_r;
      logic signed [NUM_BITS-1:0] num_t;
      logic signed [NUM_BITS-1:0] num_b;
      logic                       test;
      logic                       last;
   } rbnh_job_type;

endpackage

// ===== rtl/rbnh_div.sv =====
// ----------------------------------------------------------------------------
// rbnh_div
// Radix-2 slab divider: (num * 2^FRAC_BITS) / den rounded toward zero,
// saturated to +-(2^(FRAC_BITS+2)-1). One quotient bit a cycle.
// ----------------------------------------------------------------------------
module rbnh_div #(
   parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [rbnh_pkg::NUM_BITS-1:0]   num,
   input  logic signed [rbnh_pkg::COORD_BITS-1:0] den,
   output logic                                   done,
   output logic signed [FRAC_BITS+2:0]            quo
);
   localparam int SW = FRAC_BITS + 2;
   localparam int CW = $clog2(SW + 1);

   logic            busy_ff, done_ff, sat_ff, neg_ff;
   logic [CW-1:0]   cnt_ff;
   logic [31:0]     rem_ff, ad_ff;
   logic [SW-1:0]   quo_ff, lo_ff;

   logic [33:0]     an;
   logic [31:0]     ad_in;
   logic [32:0]     r2;
   logic            ge;
   logic [31:0]     rem_in;
   logic [SW-1:0]   mag;

   always_comb begin
      an     = num[33] ? 34'(-num) : 34'(num);
      ad_in  = den[31] ? 32'(-den) : 32'(den);
      r2     = {rem_ff, lo_ff[SW-1]};
      ge     = r2 >= {1'b0, ad_ff};
      rem_in = ge ? 32'(r2 - {1'b0, ad_ff}) : r2[31:0];
      mag    = sat_ff ? {SW{1'b1}} : quo_ff;
   end

   assign quo  = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(SW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // quotient fits SW bits unless |num| >= 4|den|
         rem_ff <= an[33:2];
         lo_ff  <= {an[1:0], {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
         ad_ff  <= ad_in;
         sat_ff <= an >= {ad_in, 2'b00};
         neg_ff <= num[33] ^ den[31];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= {lo_ff[SW-2:0], 1'b0};
         quo_ff <= {quo_ff[SW-2:0], ge};
      end
   end
endmodule

// ===== rtl/rbnh_fifo.sv =====
// ----------------------------------------------------------------------------
// rbnh_fifo
// Short request queue between the classifying front and the slab back end.
// ----------------------------------------------------------------------------
module rbnh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rbnh_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff;

   assign full  = cnt_ff == CW'(DEPTH);
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end
endmodule

// ===== rtl/rbnh_front.sv =====
// ----------------------------------------------------------------------------
// rbnh_front
// Accepts box requests, forms the four slab numerators and marks boxes that
// cannot be hit (not collidable, or outside a slab along a zero ray axis).
// ----------------------------------------------------------------------------
module rbnh_front (
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [31:0]                     box_left,
   input  logic signed [31:0]                     box_top,
   input  logic [30:0]                            box_width,
   input  logic [30:0]                            box_height,
   input  logic                                   collidable,
   input  logic                                   last_box,
   input  logic signed [31:0]                     origin_x,
   input  logic signed [31:0]                     origin_y,
   input  logic signed [31:0]                     ray_dx,
   input  logic signed [31:0]                     ray_dy,
   input  logic                                   queue_full,
   output logic                                   push,
   output rbnh_pkg::rbnh_job_type                 job
);
   logic signed [33:0] left_e, right_e, top_e, bottom_e, ox_e, oy_e;
   logic               x_out, y_out;

   always_comb begin
      left_e   = 34'(box_left);
      right_e  = 34'(box_left) + $signed({3'b000, box_width});
      top_e    = 34'(box_top);
      bottom_e = 34'(box_top) - $signed({3'b000, box_height});
      ox_e     = 34'(origin_x);
      oy_e     = 34'(origin_y);
      x_out    = (ray_dx == '0) && (ox_e < left_e || ox_e > right_e);
      y_out    = (ray_dy == '0) && (oy_e > top_e || oy_e < bottom_e);
      job.num_l = left_e - ox_e;
      job.num_r = right_e - ox_e;
      job.num_t = top_e - oy_e;
      job.num_b = bottom_e - oy_e;
      job.test  = collidable && !x_out && !y_out;
      job.last  = last_box;
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;
endmodule

// ===== rtl/rbnh_back.sv =====
// ----------------------------------------------------------------------------
// rbnh_back
// Runs the four slab divisions, merges the slabs, keeps the nearest hit and
// forms the result with its hit point on the last box of a query.
// ----------------------------------------------------------------------------
module rbnh_back #(
   parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF,
   parameter int ID_BITS   = rbnh_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [31:0]           origin_x,
   input  logic signed [31:0]           origin_y,
   input  logic signed [31:0]           ray_dx,
   input  logic signed [31:0]           ray_dy,
   input  logic                         queue_empty,
   input  rbnh_pkg::rbnh_job_type       head_job,
   input  logic [ID_BITS-1:0]           head_id,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         hit,
   output logic [ID_BITS-1:0]           hit_id,
   output logic [FRAC_BITS:0]           hit_t,
   output logic signed [31:0]           hit_x,
   output logic signed [31:0]           hit_y,
   output logic [2:0]                   hit_normal
);
   localparam int QW = FRAC_BITS + 3;
   localparam int TW = FRAC_BITS + 1;
   localparam int PW = 32 + TW + 1;
   localparam logic signed [QW-1:0] ONE_Q = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0] RND   = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_DIV, ST_EVAL, ST_MUL, ST_SUM, ST_OUT
   } state_type;

   state_type              state_ff;
   rbnh_pkg::rbnh_job_type job_ff;
   logic [ID_BITS-1:0]     id_ff;

   logic                   bv_ff;
   logic [TW-1:0]          bt_ff;
   logic [ID_BITS-1:0]     bid_ff;
   logic [2:0]             bn_ff;

   logic signed [PW-1:0]   prod_x_ff, prod_y_ff;
   logic                   rsp_valid_ff, hit_ff;
   logic [ID_BITS-1:0]     hit_id_ff;
   logic [TW-1:0]          hit_t_ff;
   logic signed [31:0]     hit_x_ff, hit_y_ff;
   logic [2:0]             hit_normal_ff;

   logic                   div_start;
   logic [3:0]             div_done;
   logic signed [QW-1:0]   q_l, q_r, q_t, q_b;

   logic signed [QW-1:0]   en, ex, tmin_a, tmax_a, tmin_b, tmax_b;
   logic [2:0]             nrm_a, nrm_b;
   logic                   box_hit, take;
   logic signed [31:0]     sum_x, sum_y;

   assign div_start = (state_ff == ST_START) && job_ff.test;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;

   rbnh_div #(.FRAC_BITS(FRAC_BITS)) u_div_l (
      .clock(clock), .reset(reset), .start(div_start), .num(job_ff.num_l),
      .den(ray_dx), .done(div_done[0]), .quo(q_l));
   rbnh_div #(.FRAC_BITS(FRAC_BITS)) u_div_r (
      .clock(clock), .reset(reset), .start(div_start), .num(job_ff.num_r),
      .den(ray_dx), .done(div_done[1]), .quo(q_r));
   rbnh_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
      .clock(clock), .reset(reset), .start(div_start), .num(job_ff.num_t),
      .den(ray_dy), .done(div_done[2]), .quo(q_t));
   rbnh_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
      .clock(clock), .reset(reset), .start(div_start), .num(job_ff.num_b),
      .den(ray_dy), .done(div_done[3]), .quo(q_b));

   function automatic logic signed [31:0] hit_coord(
      input logic signed [31:0] org,
      input logic signed [PW-1:0] prod
   );
      logic signed [PW-1:0] adj;
      logic signed [34:0]   s;
      begin
         // truncate toward zero, then saturate
         adj = prod + (prod[PW-1] ? RND : '0);
         s   = 35'(org) + 35'($signed(adj[PW-1:FRAC_BITS]));
         if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) hit_coord = s[31:0];
         else if (s[34]) hit_coord = 32'sh8000_0000;
         else hit_coord = 32'sh7fff_ffff;
      end
   endfunction

   always_comb begin
      tmin_a = '0;
      tmax_a = ONE_Q;
      nrm_a  = rbnh_pkg::NORM_NONE;
      en     = q_l;
      ex     = q_r;
      if (ray_dx != '0) begin
         if (q_l < q_r) begin
            en = q_l; ex = q_r; nrm_a = rbnh_pkg::NORM_NEG_X;
         end else begin
            en = q_r; ex = q_l; nrm_a = rbnh_pkg::NORM_POS_X;
         end
         if (en <= tmin_a) nrm_a = rbnh_pkg::NORM_NONE;
         else tmin_a = en;
         if (ex < tmax_a) tmax_a = ex;
      end
      tmin_b = tmin_a;
      tmax_b = tmax_a;
      nrm_b  = nrm_a;
      if (ray_dy != '0) begin
         if (q_t < q_b) begin
            en = q_t; ex = q_b;
            if (en > tmin_b) begin
               tmin_b = en; nrm_b = rbnh_pkg::NORM_NEG_Y;
            end
         end else begin
            en = q_b; ex = q_t;
            if (en > tmin_b) begin
               tmin_b = en; nrm_b = rbnh_pkg::NORM_POS_Y;
            end
         end
         if (ex < tmax_b) tmax_b = ex;
      end
      // a miss on x leaves the window empty through y as well
      box_hit = job_ff.test && (tmin_b <= tmax_b);
      take    = box_hit && (!bv_ff || tmin_b[TW-1:0] < bt_ff);
      sum_x   = hit_ff ? hit_coord(origin_x, prod_x_ff) : '0;
      sum_y   = hit_ff ? hit_coord(origin_y, prod_y_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bv_ff        <= 1'b0;
         bt_ff        <= '0;
         bid_ff       <= '0;
         bn_ff        <= rbnh_pkg::NORM_NONE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  job_ff   <= head_job;
                  id_ff    <= head_id;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               state_ff <= job_ff.test ? ST_DIV : ST_EVAL;
            end
            ST_DIV: begin
               if (&div_done) state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (take) begin
                  bv_ff  <= 1'b1;
                  bt_ff  <= tmin_b[TW-1:0];
                  bid_ff <= id_ff;
                  bn_ff  <= nrm_b;
               end
               state_ff <= job_ff.last ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
               hit_ff        <= bv_ff;
               hit_id_ff     <= bid_ff;
               hit_t_ff      <= bt_ff;
               hit_normal_ff <= bn_ff;
               prod_x_ff     <= ray_dx * $signed({1'b0, bt_ff});
               prod_y_ff     <= ray_dy * $signed({1'b0, bt_ff});
               // clear the running hit for the next query
               bv_ff    <= 1'b0;
               bt_ff    <= '0;
               bid_ff   <= '0;
               bn_ff    <= rbnh_pkg::NORM_NONE;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               hit_x_ff     <= sum_x;
               hit_y_ff     <= sum_y;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign hit        = hit_ff;
   assign hit_id     = hit_id_ff;
   assign hit_t      = hit_t_ff;
   assign hit_x      = hit_x_ff;
   assign hit_y      = hit_y_ff;
   assign hit_normal = hit_normal_ff;
endmodule

// ===== rtl/ray_box_nearest_hit_top.sv =====
// A tested box passes ST_IDLE, ST_START, ST_DIV and ST_EVAL in the back end, with
// ST_DIV held by the bit-serial slab dividers; a skipped box skips ST_DIV.
// The back end works on one box at a time; the last box of a query also passes
// ST_MUL and ST_SUM; rsp_valid then rises with the result and holds until taken.
// Reset clears the queue, the running nearest hit and sets the ray to (1.0, 0).
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_top
// Streams axis-aligned boxes against a 2D ray segment and reports the nearest
// entry hit once per query.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_top #(
   parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF,
   parameter int ID_BITS   = rbnh_pkg::ID_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [31:0]                    req_box_left,
   input  logic signed [31:0]                    req_box_top,
   input  logic [30:0]                           req_box_width,
   input  logic [30:0]                           req_box_height,
   input  logic                                  req_collidable,
   input  logic [ID_BITS-1:0]                    req_object_id,
   input  logic                                  req_last_box,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [ID_BITS-1:0]                    rsp_hit_id,
   output logic [FRAC_BITS:0]                    rsp_hit_t,
   output logic signed [31:0]                    rsp_hit_x,
   output logic signed [31:0]                    rsp_hit_y,
   output logic [2:0]                            rsp_hit_normal,
   input  logic                                  csr_we,
   input  logic [rbnh_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [31:0]                           csr_wdata
);
   localparam int JW = $bits(rbnh_pkg::rbnh_job_type);

   logic signed [31:0]     origin_x_ff, origin_y_ff, ray_dx_ff, ray_dy_ff;
   logic                   push, pop, q_full, q_empty;
   rbnh_pkg::rbnh_job_type job_in, job_out;
   logic [ID_BITS-1:0]     id_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         ray_dx_ff   <= 32'sd1 <<< FRAC_BITS;
         ray_dy_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rbnh_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            rbnh_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            rbnh_pkg::CSR_RAY_DX:   ray_dx_ff   <= csr_wdata;
            rbnh_pkg::CSR_RAY_DY:   ray_dy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   rbnh_front u_front (
      .req_valid(req_valid), .req_ready(req_ready),
      .box_left(req_box_left), .box_top(req_box_top),
      .box_width(req_box_width), .box_height(req_box_height),
      .collidable(req_collidable), .last_box(req_last_box),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff),
      .ray_dx(ray_dx_ff), .ray_dy(ray_dy_ff),
      .queue_full(q_full), .push(push), .job(job_in));

   rbnh_fifo #(.WIDTH(JW + ID_BITS), .DEPTH(rbnh_pkg::QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push),
      .wdata({job_in, req_object_id}), .pop(pop),
      .rdata({job_out, id_out}), .full(q_full), .empty(q_empty));

   rbnh_back #(.FRAC_BITS(FRAC_BITS), .ID_BITS(ID_BITS)) u_back (
      .clock(clock), .reset(reset),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff),
      .ray_dx(ray_dx_ff), .ray_dy(ray_dy_ff),
      .queue_empty(q_empty), .head_job(job_out), .head_id(id_out), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .hit(rsp_hit), .hit_id(rsp_hit_id), .hit_t(rsp_hit_t),
      .hit_x(rsp_hit_x), .hit_y(rsp_hit_y), .hit_normal(rsp_hit_normal));
endmodule
